@@ design/drfu_pkg.sv @@
// Package for the dirty-rectangle framebuffer update block.
// Holds shared codes, widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package drfu_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int HEADER_BYTES   = 24;
  localparam int HEADER_WORDS   = HEADER_BYTES / 4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // func codes
  localparam logic [1:0] FUNC_BODY  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STALE   = 2'd1;
  localparam logic [1:0] ST_BADRECT = 2'd2;
  localparam logic [1:0] ST_BADLEN  = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FILL   = 2'd2;

  localparam logic [6:0]  RST_WIDTH  = 7'd32;
  localparam logic [6:0]  RST_HEIGHT = 7'd16;
  localparam logic [31:0] RST_COLOR  = 32'hFF0000FF;

  typedef struct packed {
    logic accept_body;
    logic accept_read;
    logic chk1;
    logic chk2;
    logic chk3;
    logic copy_step;
    logic fill_step;
    logic fill_reset_color;
    logic seq_commit;
    logic seq_clear;
    logic load_msg;
    logic load_pix;
  } cmd_t;

  typedef struct packed {
    logic chk_ok;
    logic copy_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

@@ design/drfu_ctrl.sv @@
// Controller state machine for the framebuffer update block.
// Drives drfu_dp through drfu_pkg::cmd_t and reads back drfu_pkg::sts_t.
`timescale 1ns / 1ps

module drfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_func_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  drfu_pkg::sts_t    sts_i,
  output drfu_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_INIT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_CHK1    = 9'b000000100,
    S_CHK2    = 9'b000001000,
    S_CHK3    = 9'b000010000,
    S_COPY    = 9'b000100000,
    S_MSG_OUT = 9'b001000000,
    S_RD_OUT  = 9'b010000000,
    S_CLEAR   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill_step        = 1'b1;
        cmd_o.fill_reset_color = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          unique case (in_func_i)
            drfu_pkg::FUNC_BODY: begin
              cmd_o.accept_body = 1'b1;
              if (in_last_i) state_d = S_CHK1;
            end
            drfu_pkg::FUNC_READ: begin
              cmd_o.accept_read = 1'b1;
              state_d           = S_RD_OUT;
            end
            drfu_pkg::FUNC_CLEAR: begin
              cmd_o.seq_clear = 1'b1;
              state_d         = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_CHK1: begin
        cmd_o.chk1 = 1'b1;
        state_d    = S_CHK2;
      end
      S_CHK2: begin
        cmd_o.chk2 = 1'b1;
        state_d    = S_CHK3;
      end
      S_CHK3: begin
        cmd_o.chk3 = 1'b1;
        state_d    = sts_i.chk_ok ? S_COPY : S_MSG_OUT;
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.seq_commit = 1'b1;
          state_d          = S_MSG_OUT;
        end
      end
      S_MSG_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_msg = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/drfu_dp.sv @@
// Datapath of the framebuffer update block: config registers, header latch,
// staging and frame memories, checks, copy and fill sweeps, output register.
// Depends on drfu_pkg; sequenced by drfu_ctrl.
`timescale 1ns / 1ps

module drfu_dp #(
  parameter int MAX_WIDTH  = drfu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drfu_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic [31:0]                         body_word_i,
  input  logic                                last_i,
  input  logic [2:0]                          tail_bytes_i,
  input  logic [5:0]                          read_x_i,
  input  logic [5:0]                          read_y_i,
  input  drfu_pkg::cmd_t                      cmd_i,
  output drfu_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_kind_o,
  output logic [drfu_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DMAX  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW    = $clog2(DMAX + 1);
  localparam int PW    = 2 * DW;

  logic [6:0]  width_q, height_q;
  logic [31:0] fill_q;

  logic [31:0] hdr_q [drfu_pkg::HEADER_WORDS];
  logic [31:0] byte_cnt_q;
  logic        ovf_q;
  logic [31:0] seq_q;

  logic [31:0] stg_mem   [DEPTH];
  logic [31:0] frame_mem [DEPTH];

  logic [DW-1:0] fw, fh, w_q, h_q, x_q, y_q;
  logic [PW-1:0] prod_q;
  logic [1:0]    status_q;
  logic [AW-1:0] k_q, dst_q, fill_addr_q, rd_addr;
  logic [31:0]   stg_rd_q, rd_q;
  logic          wr_pend_q, in_frame, pix_in_q;

  // effective frame size
  always_comb begin
    if (width_q == 7'd0) fw = DW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) fw = DW'(MAX_WIDTH);
    else fw = DW'(width_q);
    if (height_q == 7'd0) fh = DW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) fh = DW'(MAX_HEIGHT);
    else fh = DW'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= drfu_pkg::RST_WIDTH;
      height_q <= drfu_pkg::RST_HEIGHT;
      fill_q   <= drfu_pkg::RST_COLOR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        drfu_pkg::REG_WIDTH:  width_q  <= cfg_data_i[6:0];
        drfu_pkg::REG_HEIGHT: height_q <= cfg_data_i[6:0];
        drfu_pkg::REG_FILL:   fill_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // message assembly
  logic [29:0] widx, stg_off;
  logic [2:0]  add_b;
  logic [32:0] sum;

  assign widx    = byte_cnt_q[31:2];
  assign stg_off = widx - 30'(drfu_pkg::HEADER_WORDS);
  assign add_b   = (last_i && tail_bytes_i != 3'd0 && tail_bytes_i <= 3'd4) ?
                   tail_bytes_i : 3'd4;
  assign sum     = {1'b0, byte_cnt_q} + 33'(add_b);

  // checks
  logic signed [32:0] l_s, t_s, r_s, b_s, fw_s, fh_s;
  logic               len_bad, stale, rect_bad, chk_ok;

  assign l_s  = {hdr_q[1][31], hdr_q[1]};
  assign t_s  = {hdr_q[2][31], hdr_q[2]};
  assign r_s  = {hdr_q[3][31], hdr_q[3]};
  assign b_s  = {hdr_q[4][31], hdr_q[4]};
  assign fw_s = $signed(33'(fw));
  assign fh_s = $signed(33'(fh));

  assign len_bad  = (byte_cnt_q < 32'(drfu_pkg::HEADER_BYTES)) ||
                    ({1'b0, byte_cnt_q} !=
                     33'(drfu_pkg::HEADER_BYTES) + {1'b0, hdr_q[5]});
  assign stale    = hdr_q[0] < seq_q;
  assign rect_bad = (l_s < 0) || (t_s < 0) || (r_s > fw_s) || (b_s > fh_s) ||
                    (r_s <= l_s) || (b_s <= t_s);
  assign chk_ok   = (status_q == drfu_pkg::ST_OK) && !ovf_q &&
                    (34'({prod_q, 2'b00}) == 34'(hdr_q[5]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      ovf_q      <= 1'b0;
      seq_q      <= '0;
      for (int i = 0; i < drfu_pkg::HEADER_WORDS; i++) hdr_q[i] <= '0;
    end else begin
      if (cmd_i.accept_body) begin
        if (widx < 30'(drfu_pkg::HEADER_WORDS)) hdr_q[widx[2:0]] <= body_word_i;
        else if (stg_off >= 30'(DEPTH)) ovf_q <= 1'b1;
        byte_cnt_q <= sum[32] ? '1 : sum[31:0];
      end
      if (cmd_i.load_msg) begin
        byte_cnt_q <= '0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.seq_commit) seq_q <= hdr_q[0];
      else if (cmd_i.seq_clear) seq_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_body && widx >= 30'(drfu_pkg::HEADER_WORDS) &&
        stg_off < 30'(DEPTH)) begin
      stg_mem[stg_off[AW-1:0]] <= body_word_i;
    end
    if (cmd_i.copy_step) stg_rd_q <= stg_mem[k_q];
  end

  // check pipeline and copy addressing
  always_ff @(posedge clk_i) begin
    if (cmd_i.chk1) begin
      if (len_bad) status_q <= drfu_pkg::ST_BADLEN;
      else if (stale) status_q <= drfu_pkg::ST_STALE;
      else if (rect_bad) status_q <= drfu_pkg::ST_BADRECT;
      else status_q <= drfu_pkg::ST_OK;
      w_q <= DW'(hdr_q[3] - hdr_q[1]);
      h_q <= DW'(hdr_q[4] - hdr_q[2]);
    end
    if (cmd_i.chk2) prod_q <= PW'(w_q) * PW'(h_q);
    if (cmd_i.chk3) begin
      if (!chk_ok && status_q == drfu_pkg::ST_OK) status_q <= drfu_pkg::ST_BADLEN;
      k_q <= '0;
      x_q <= DW'(hdr_q[1]);
      y_q <= DW'(hdr_q[2]);
    end
    if (cmd_i.copy_step) begin
      k_q   <= k_q + AW'(1);
      dst_q <= AW'(32'(y_q) * 32'(MAX_WIDTH) + 32'(x_q));
      if (x_q == DW'(hdr_q[3]) - DW'(1)) begin
        x_q <= DW'(hdr_q[1]);
        y_q <= y_q + DW'(1);
      end else begin
        x_q <= x_q + DW'(1);
      end
    end
  end

  // frame store: fill sweep, copy writes, pixel reads
  assign in_frame = (32'(read_x_i) < 32'(fw)) && (32'(read_y_i) < 32'(fh));
  assign rd_addr  = in_frame ?
                    AW'(32'(read_y_i) * 32'(MAX_WIDTH) + 32'(read_x_i)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) begin
      frame_mem[fill_addr_q] <= cmd_i.fill_reset_color ? drfu_pkg::RST_COLOR : fill_q;
    end else if (wr_pend_q) begin
      frame_mem[dst_q] <= stg_rd_q;
    end
    if (cmd_i.accept_read) begin
      rd_q     <= frame_mem[rd_addr];
      pix_in_q <= in_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_addr_q <= '0;
      wr_pend_q   <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.copy_step;
      if (cmd_i.fill_step) begin
        fill_addr_q <= sts_o.fill_last ? '0 : fill_addr_q + AW'(1);
      end
    end
  end

  // output register
  logic [1:0]  o_status_q;
  logic        o_pv_q, o_kind_q, out_valid_q;
  logic [31:0] o_pix_q, o_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_msg || cmd_i.load_pix) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_msg) begin
      o_kind_q   <= drfu_pkg::KIND_STATUS;
      o_status_q <= status_q;
      o_pv_q     <= 1'b0;
      o_pix_q    <= '0;
      o_seq_q    <= seq_q;
    end else if (cmd_i.load_pix) begin
      o_kind_q   <= drfu_pkg::KIND_PIXEL;
      o_status_q <= drfu_pkg::ST_OK;
      o_pv_q     <= pix_in_q;
      o_pix_q    <= pix_in_q ? rd_q : '0;
      o_seq_q    <= seq_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = o_kind_q;
  assign out_data_o  = {5'd0, o_seq_q, o_pix_q[7:0], o_pix_q[15:8],
                        o_pix_q[23:16], o_pix_q[31:24], o_pv_q, o_status_q};

  assign sts_o.chk_ok    = chk_ok;
  assign sts_o.copy_last = (33'(k_q) + 33'd1) == 33'(prod_q);
  assign sts_o.fill_last = fill_addr_q == AW'(DEPTH - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ design/dirty_rect_framebuffer_update.sv @@
// Top level of the dirty-rectangle framebuffer update block.
// Depends on drfu_pkg, drfu_ctrl and drfu_dp.
//
// Input stream: tuser carries func (body word, read pixel, clear), tlast
// marks the final body word, tdata carries the word, tail byte count and the
// read coordinate. Output stream: tuser is the result kind, tdata the status,
// pixel data and newest accepted sequence.
// Body words that are not last are taken one per cycle and give no result.
// The last word starts the check steps CHK1, CHK2 and CHK3; a message that
// passes then copies the rectangle from staging into the frame store, one
// pixel per cycle over the single frame write port; the status follows.
// A read captures the pixel, then loads it into the output register once
// that is free. A clear rewrites every frame pixel and gives no result.
// After reset the same sweep writes opaque blue to the whole frame store
// with s_tready_o low; config writes are taken at any time. A result
// waiting on a stalled receiver sits in the output register; new items are
// still taken until another result is due.
`timescale 1ns / 1ps

module dirty_rect_framebuffer_update #(
  parameter int MAX_WIDTH  = drfu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = drfu_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // body_word[31:0], tail_bytes[34:32], read_x[40:35], read_y[46:41]
  input  logic [drfu_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  // func[1:0]
  input  logic [1:0]                       s_tuser_i,
  input  logic                             s_tlast_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // status[1:0], pixel_valid[2], alpha[10:3], red[18:11], green[26:19],
  // blue[34:27], newest_sequence[66:35]
  output logic [drfu_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  // result_kind[0]
  output logic                             m_tuser_o
);

  drfu_pkg::cmd_t cmd;
  drfu_pkg::sts_t sts;

  drfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_func_i  (s_tuser_i),
    .in_last_i  (s_tlast_i),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drfu_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .body_word_i  (s_tdata_i[31:0]),
    .last_i       (s_tlast_i),
    .tail_bytes_i (s_tdata_i[34:32]),
    .read_x_i     (s_tdata_i[40:35]),
    .read_y_i     (s_tdata_i[46:41]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_kind_o   (m_tuser_o),
    .out_data_o   (m_tdata_o)
  );

  // status results never carry pixel data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == drfu_pkg::KIND_STATUS) |->
      (m_tdata_o[34:2] == '0))
    else $error("status result carries pixel data");

  // pixel results carry status ok, and no color when outside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == drfu_pkg::KIND_PIXEL) |->
      (m_tdata_o[1:0] == drfu_pkg::ST_OK && (m_tdata_o[2] || m_tdata_o[34:3] == '0)))
    else $error("malformed pixel result");

  // no new item is taken in the cycle right after a last body word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tuser_i == drfu_pkg::FUNC_BODY && s_tlast_i)
      |=> !s_tready_o)
    else $error("input taken during message checks");

endmodule
